// File: hw/rtl/rvu_pkg.sv
// shared types and constants of the relaxed vector update block
package rvu_pkg;

	localparam int NUM_COEFFS_DEF = 256;

	// configuration port
	localparam int CFG_DATA_W = 32;
	localparam int CFG_IDX_W  = 2;
	localparam logic [CFG_IDX_W-1:0] REG_RELAX_FACTOR = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CHANGE_TOL   = 2'd1;

	localparam int RELAX_W = 17;
	localparam logic [RELAX_W-1:0] RELAX_RESET = 17'd65536;
	localparam logic [31:0]        TOL_RESET   = 32'd66;

	// job queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

	typedef struct packed {
		logic signed [31:0] new_cos;
		logic signed [31:0] new_sin;
		logic               last;
	} item_t;

	typedef struct packed {
		logic signed [31:0] relaxed_cos;
		logic signed [31:0] relaxed_sin;
		logic               change_valid;
		logic [31:0]        relative_change;
		logic               change_infinite;
		logic               converged;
	} result_t;

	typedef struct packed {
		logic signed [31:0] rc;
		logic signed [31:0] rs;
		logic               last;
		logic               first;
		logic [63:0]        change_sum;
		logic [63:0]        norm_sum;
	} job_t;

endpackage

// File: hw/rtl/rvu_fifo.sv
// two-entry job queue between the front and back parts
module rvu_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  rvu_pkg::job_t wr_data,
	output logic          full,
	input  logic          rd_en,
	output rvu_pkg::job_t rd_data,
	output logic          empty
);

	rvu_pkg::job_t                     mem_q [rvu_pkg::QUEUE_DEPTH];
	logic [rvu_pkg::QUEUE_PTR_W-1:0]   wr_ptr_q;
	logic [rvu_pkg::QUEUE_PTR_W-1:0]   rd_ptr_q;
	logic [rvu_pkg::QUEUE_PTR_W:0]     cnt_q;
	logic                              do_wr;
	logic                              do_rd;

	assign full    = (cnt_q == (rvu_pkg::QUEUE_PTR_W+1)'(rvu_pkg::QUEUE_DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// File: hw/rtl/rvu_front.sv
// front part: store read, relaxation, squares and running sums
module rvu_front #(
	parameter int NUM_COEFFS = rvu_pkg::NUM_COEFFS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	output logic                         full,
	input  rvu_pkg::item_t               item,
	input  logic [rvu_pkg::RELAX_W-1:0]  relax_factor,
	output logic                         job_push,
	output rvu_pkg::job_t                job,
	input  logic                         job_full
);

	localparam int IDX_W = (NUM_COEFFS > 1) ? $clog2(NUM_COEFFS) : 1;

	typedef enum logic [4:0] {
		F_IDLE = 5'b00001,
		F_MUL  = 5'b00010,
		F_ADD  = 5'b00100,
		F_SQ   = 5'b01000,
		F_ACC  = 5'b10000
	} fstate_t;

	fstate_t                st_q;
	rvu_pkg::item_t         item_q;
	logic [IDX_W-1:0]       idx_q;
	logic                   have_q;
	logic [63:0]            cs_q;
	logic [63:0]            ns_q;
	logic signed [31:0]     old_cos_q;
	logic signed [31:0]     old_sin_q;
	logic signed [50:0]     prod_c_q;
	logic signed [50:0]     prod_s_q;
	logic signed [31:0]     rc_q;
	logic signed [31:0]     rs_q;
	logic [63:0]            sq_dc_q;
	logic [63:0]            sq_ds_q;
	logic [63:0]            sq_nc_q;
	logic [63:0]            sq_ns_q;
	logic signed [31:0]     cos_mem [NUM_COEFFS];
	logic signed [31:0]     sin_mem [NUM_COEFFS];

	logic signed [31:0]     rc_nx;
	logic signed [31:0]     rs_nx;
	logic [65:0]            cs_sum;
	logic [65:0]            ns_sum;
	logic [63:0]            cs_sat;
	logic [63:0]            ns_sat;
	logic signed [17:0]     factor_s;

	// old + round_half_up(prod / 65536), clamped to 32 bits
	function automatic logic signed [31:0] relax_sat(input logic signed [31:0] old,
	                                                input logic signed [50:0] prod);
		logic signed [51:0] p;
		logic signed [36:0] r;
		p = {prod[50], prod} + 52'sd32768;
		r = {{5{old[31]}}, old} + {p[51], p[51:16]};
		if (r[36:31] == 6'b000000 || r[36:31] == 6'b111111) begin
			relax_sat = r[31:0];
		end else if (r[36]) begin
			relax_sat = 32'sh8000_0000;
		end else begin
			relax_sat = 32'sh7fff_ffff;
		end
	endfunction

	function automatic logic [31:0] mag_diff(input logic signed [31:0] a,
	                                        input logic signed [31:0] b);
		logic signed [32:0] d;
		d = {a[31], a} - {b[31], b};
		mag_diff = d[32] ? 32'(-d) : d[31:0];
	endfunction

	assign factor_s = $signed({1'b0, relax_factor});
	assign rc_nx    = have_q ? relax_sat(old_cos_q, prod_c_q) : item_q.new_cos;
	assign rs_nx    = have_q ? relax_sat(old_sin_q, prod_s_q) : item_q.new_sin;

	// saturating at 2^64 - 1 once is the same as after each addition
	assign cs_sum = {2'b00, cs_q} + {2'b00, sq_dc_q} + {2'b00, sq_ds_q};
	assign ns_sum = {2'b00, ns_q} + {2'b00, sq_nc_q} + {2'b00, sq_ns_q};
	assign cs_sat = (cs_sum[65:64] != 2'b00) ? '1 : cs_sum[63:0];
	assign ns_sat = (ns_sum[65:64] != 2'b00) ? '1 : ns_sum[63:0];

	assign full     = (st_q != F_IDLE);
	assign job_push = (st_q == F_ACC) && !job_full;

	always_comb begin
		job.rc         = rc_q;
		job.rs         = rs_q;
		job.last       = item_q.last;
		job.first      = !have_q;
		job.change_sum = cs_sat;
		job.norm_sum   = ns_sat;
	end

	// coefficient stores
	always_ff @(posedge clk) begin
		if (st_q == F_IDLE && push) begin
			old_cos_q <= cos_mem[idx_q];
			old_sin_q <= sin_mem[idx_q];
		end
		if (st_q == F_ADD) begin
			cos_mem[idx_q] <= rc_nx;
			sin_mem[idx_q] <= rs_nx;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (st_q == F_IDLE && push) begin
			item_q <= item;
		end
		if (st_q == F_MUL) begin
			prod_c_q <= ($signed({item_q.new_cos[31], item_q.new_cos})
			            - $signed({old_cos_q[31], old_cos_q})) * factor_s;
			prod_s_q <= ($signed({item_q.new_sin[31], item_q.new_sin})
			            - $signed({old_sin_q[31], old_sin_q})) * factor_s;
		end
		if (st_q == F_ADD) begin
			rc_q <= rc_nx;
			rs_q <= rs_nx;
		end
		if (st_q == F_SQ) begin
			sq_dc_q <= 64'(mag_diff(rc_q, old_cos_q)) * 64'(mag_diff(rc_q, old_cos_q));
			sq_ds_q <= 64'(mag_diff(rs_q, old_sin_q)) * 64'(mag_diff(rs_q, old_sin_q));
			sq_nc_q <= 64'(mag_diff(rc_q, 32'sd0)) * 64'(mag_diff(rc_q, 32'sd0));
			sq_ns_q <= 64'(mag_diff(rs_q, 32'sd0)) * 64'(mag_diff(rs_q, 32'sd0));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= F_IDLE;
			idx_q  <= '0;
			have_q <= 1'b0;
			cs_q   <= '0;
			ns_q   <= '0;
		end else begin
			unique case (st_q)
				F_IDLE: begin
					if (push) begin
						st_q <= F_MUL;
					end
				end
				F_MUL: st_q <= F_ADD;
				F_ADD: st_q <= F_SQ;
				F_SQ:  st_q <= F_ACC;
				F_ACC: begin
					if (!job_full) begin
						st_q <= F_IDLE;
						if (item_q.last) begin
							cs_q   <= '0;
							ns_q   <= '0;
							idx_q  <= '0;
							have_q <= 1'b1;
						end else begin
							cs_q  <= cs_sat;
							ns_q  <= ns_sat;
							idx_q <= (idx_q == IDX_W'(NUM_COEFFS - 1)) ? '0 : idx_q + 1'b1;
						end
					end
				end
				default: st_q <= F_IDLE;
			endcase
		end
	end

endmodule

// File: hw/rtl/rvu_back.sv
// back part: roots, division and the result register
module rvu_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             job_empty,
	input  rvu_pkg::job_t    job,
	output logic             job_pop,
	input  logic [31:0]      tolerance,
	output logic             empty,
	input  logic             pop,
	output rvu_pkg::result_t result
);

	typedef enum logic [3:0] {
		B_IDLE = 4'b0001,
		B_SQRT = 4'b0010,
		B_DIV  = 4'b0100,
		B_OUT  = 4'b1000
	} bstate_t;

	typedef struct packed {
		logic [63:0] x;
		logic [63:0] res;
	} sqrt_t;

	bstate_t             st_q;
	logic [5:0]          cnt_q;
	logic signed [31:0]  rc_q;
	logic signed [31:0]  rs_q;
	logic [63:0]         xc_q;
	logic [63:0]         xn_q;
	logic [63:0]         resc_q;
	logic [63:0]         resn_q;
	logic [63:0]         bit_q;
	logic [47:0]         num_q;
	logic [31:0]         den_q;
	logic [31:0]         rem_q;
	rvu_pkg::result_t    out_q;
	logic                out_valid_q;

	sqrt_t               sc_nx;
	sqrt_t               sn_nx;
	logic [32:0]         trial;
	logic                qbit;
	logic                out_free;
	logic                simple;
	logic [31:0]         rel;

	function automatic sqrt_t sqrt_step(input logic [63:0] x, input logic [63:0] res,
	                                   input logic [63:0] b);
		sqrt_t o;
		if (x >= res + b) begin
			o.x   = x - (res + b);
			o.res = (res >> 1) + b;
		end else begin
			o.x   = x;
			o.res = res >> 1;
		end
		sqrt_step = o;
	endfunction

	assign sc_nx    = sqrt_step(xc_q, resc_q, bit_q);
	assign sn_nx    = sqrt_step(xn_q, resn_q, bit_q);
	assign trial    = {rem_q, num_q[47]};
	assign qbit     = (trial >= {1'b0, den_q});
	assign out_free = !out_valid_q || pop;
	assign simple   = !job.last || job.first;
	assign rel      = (num_q[47:32] != 16'h0) ? '1 : num_q[31:0];
	assign empty    = !out_valid_q;
	assign result   = out_q;

	always_comb begin
		job_pop = 1'b0;
		if (st_q == B_IDLE && !job_empty) begin
			job_pop = simple ? out_free : 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			B_IDLE: begin
				if (!job_empty && !simple) begin
					rc_q   <= job.rc;
					rs_q   <= job.rs;
					xc_q   <= job.change_sum;
					xn_q   <= job.norm_sum;
					resc_q <= '0;
					resn_q <= '0;
					bit_q  <= 64'h4000_0000_0000_0000;
				end
			end
			B_SQRT: begin
				xc_q   <= sc_nx.x;
				xn_q   <= sn_nx.x;
				resc_q <= sc_nx.res;
				resn_q <= sn_nx.res;
				bit_q  <= bit_q >> 2;
				if (cnt_q == 6'd31) begin
					num_q <= {sc_nx.res[31:0], 16'h0};
					den_q <= (sn_nx.res == '0) ? 32'd1 : sn_nx.res[31:0];
					rem_q <= '0;
				end
			end
			B_DIV: begin
				rem_q <= qbit ? 32'(trial - {1'b0, den_q}) : trial[31:0];
				num_q <= {num_q[46:0], qbit};
			end
			B_OUT: ;
			default: ;
		endcase
		if (job_pop && simple) begin
			out_q.relaxed_cos     <= job.rc;
			out_q.relaxed_sin     <= job.rs;
			out_q.change_valid    <= job.last;
			out_q.relative_change <= job.last ? '1 : '0;
			out_q.change_infinite <= job.last;
			out_q.converged       <= 1'b0;
		end else if (st_q == B_OUT && out_free) begin
			out_q.relaxed_cos     <= rc_q;
			out_q.relaxed_sin     <= rs_q;
			out_q.change_valid    <= 1'b1;
			out_q.relative_change <= rel;
			out_q.change_infinite <= 1'b0;
			out_q.converged       <= (rel <= tolerance);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= B_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if ((job_pop && simple) || (st_q == B_OUT && out_free)) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
			unique case (st_q)
				B_IDLE: begin
					if (!job_empty && !simple) begin
						st_q  <= B_SQRT;
						cnt_q <= '0;
					end
				end
				B_SQRT: begin
					if (cnt_q == 6'd31) begin
						st_q  <= B_DIV;
						cnt_q <= '0;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				B_DIV: begin
					if (cnt_q == 6'd47) begin
						st_q  <= B_OUT;
						cnt_q <= '0;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				B_OUT: begin
					if (out_free) begin
						st_q <= B_IDLE;
					end
				end
				default: st_q <= B_IDLE;
			endcase
		end
	end

endmodule

// File: hw/rtl/relaxed_vector_update_with_change_norm_unit.sv
// top level of the relaxed coefficient update with relative change norm
//
// input queue side: an item (new cos, new sin, last flag) is taken when push is
// high and full is low. result queue side: the oldest result sits on result
// while empty is low and leaves when pop is high.
// every item gives exactly one result, in order. the front part takes a new item
// only once it is done with the last one: store read, multiply, round and clamp
// with write-back, squares, then the saturating sum update; the store has a
// single port. a result for an ordinary item goes into the result register when
// the back part pops its job. the final item of a vector that has a
// predecessor goes through two 64-bit roots (one result bit per cycle) and a
// 48-step restoring division before its result shows. a two-entry job queue
// sits between front and back, so the front keeps taking items while the back
// divides or while the receiver does not pop. when the receiver stalls, the
// result register holds, the job queue fills, and then full stays high.
// reset clears the sums, the element index and the first-vector mark; the
// coefficient stores are not cleared, the first vector writes them.
// relax_factor and change_tolerance are written through wr_en/wr_index/wr_data;
// the user must write them only while the block is idle, the block itself does
// not enforce it; unknown indexes are ignored.
module relaxed_vector_update_with_change_norm_unit #(
	parameter int NUM_COEFFS = rvu_pkg::NUM_COEFFS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	output logic                              full,
	input  rvu_pkg::item_t                    item,
	output logic                              empty,
	input  logic                              pop,
	output rvu_pkg::result_t                  result,
	input  logic                              wr_en,
	input  logic [rvu_pkg::CFG_IDX_W-1:0]     wr_index,
	input  logic [rvu_pkg::CFG_DATA_W-1:0]    wr_data
);

	logic [rvu_pkg::RELAX_W-1:0] relax_q;
	logic [31:0]                 tol_q;
	logic                        job_push;
	logic                        job_full;
	logic                        job_pop;
	logic                        job_empty;
	rvu_pkg::job_t               job_in;
	rvu_pkg::job_t               job_out;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			relax_q <= rvu_pkg::RELAX_RESET;
			tol_q   <= rvu_pkg::TOL_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				rvu_pkg::REG_RELAX_FACTOR: relax_q <= wr_data[rvu_pkg::RELAX_W-1:0];
				rvu_pkg::REG_CHANGE_TOL:   tol_q   <= wr_data[31:0];
				default: ;
			endcase
		end
	end

	// front: relaxation and sums, one item at a time
	rvu_front #(
		.NUM_COEFFS(NUM_COEFFS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.item         (item),
		.relax_factor (relax_q),
		.job_push     (job_push),
		.job          (job_in),
		.job_full     (job_full)
	);

	// decoupling queue
	rvu_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (job_push),
		.wr_data (job_in),
		.full    (job_full),
		.rd_en   (job_pop),
		.rd_data (job_out),
		.empty   (job_empty)
	);

	// back: end-of-vector norm and the result register
	rvu_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_empty (job_empty),
		.job       (job_out),
		.job_pop   (job_pop),
		.tolerance (tol_q),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);

endmodule

// File: hw/rtl/rvu_chk.sv
// port-level checks of the relaxed vector update block and their binding
module rvu_chk (
	input logic             clk,
	input logic             arst_n,
	input logic             empty,
	input logic             pop,
	input rvu_pkg::result_t result
);

	// a waiting result stays put until it is taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(result)))
		else $error("result changed while waiting");

	// change fields are zero on items that do not end a vector
	a_plain: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !result.change_valid) |->
		(result.relative_change == 32'h0 && !result.change_infinite && !result.converged))
		else $error("change fields set on an item that does not end a vector");

	// an infinite change reads as full scale and never converges
	a_inf: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.change_infinite) |->
		(result.change_valid && result.relative_change == 32'hffff_ffff && !result.converged))
		else $error("infinite change not reported as full scale");

	// a converged flag only comes with a valid, finite change
	a_conv: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.converged) |-> (result.change_valid && !result.change_infinite))
		else $error("converged flag on an invalid or infinite change");

endmodule

bind relaxed_vector_update_with_change_norm_unit rvu_chk u_rvu_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.empty  (empty),
	.pop    (pop),
	.result (result)
);

// File: dv/relaxed_vector_update_with_change_norm_unit_test.sv
// self-checking testbench for the relaxed vector update block
module relaxed_vector_update_with_change_norm_unit_test;

	// index with no register behind it, writes there must do nothing
	localparam logic [rvu_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam int NCOEF = rvu_pkg::NUM_COEFFS_DEF;
	// the slow path runs two roots and a divide
	localparam int SETTLE_CYCLES = 120;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	rvu_pkg::item_t item = '0;
	logic empty;
	logic pop = 1'b0;
	rvu_pkg::result_t result;
	logic wr_en = 1'b0;
	logic [rvu_pkg::CFG_IDX_W-1:0] wr_index = '0;
	logic [rvu_pkg::CFG_DATA_W-1:0] wr_data = '0;

	// cycle count, used to place a long stretch without idling on both sides
	int unsigned cyc = 0;

	always #5 clk = ~clk;
	always @(posedge clk) cyc <= cyc + 1;

	relaxed_vector_update_with_change_norm_unit dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .item(item),
		.empty(empty), .pop(pop), .result(result),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
	);

	// tracks the block's state and holds the results still owed by it
	class update_scoreboard;
		logic [rvu_pkg::RELAX_W-1:0] factor;
		logic [31:0] tolerance;
		logic signed [31:0] cos_mem[NCOEF];
		logic signed [31:0] sin_mem[NCOEF];
		bit seen_vector;
		int unsigned slot;
		logic [63:0] delta_acc;
		logic [63:0] norm_acc;
		rvu_pkg::result_t owed[$];
		int errors;

		function new();
			factor = rvu_pkg::RELAX_RESET;
			tolerance = rvu_pkg::TOL_RESET;
			seen_vector = 0;
			slot = 0;
			delta_acc = '0;
			norm_acc = '0;
			errors = 0;
		endfunction

		function void write_reg(logic [rvu_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
			if (idx == rvu_pkg::REG_RELAX_FACTOR)
				factor = data[rvu_pkg::RELAX_W-1:0];
			else if (idx == rvu_pkg::REG_CHANGE_TOL)
				tolerance = data;
		endfunction

		function logic signed [31:0] relax(logic signed [31:0] old,
				logic signed [31:0] nw);
			longint d, p, r;
			d = longint'(nw) - longint'(old);
			p = d * longint'({15'd0, factor}) + 64'sd32768;
			// arithmetic shift is floor, so this rounds half up
			r = longint'(old) + (p >>> 16);
			if (r > 64'sd2147483647) r = 64'sd2147483647;
			if (r < -64'sd2147483648) r = -64'sd2147483648;
			return r[31:0];
		endfunction

		function logic [63:0] square(longint v);
			logic [63:0] m;
			m = (v < 0) ? -v : v;
			return m * m;
		endfunction

		function logic [63:0] sat_add(logic [63:0] a, logic [63:0] b);
			logic [64:0] s;
			s = {1'b0, a} + {1'b0, b};
			return s[64] ? '1 : s[63:0];
		endfunction

		function logic [63:0] root64(logic [63:0] x);
			logic [63:0] r, b;
			r = '0;
			b = 64'h4000_0000_0000_0000;
			while (b > x) b >>= 2;
			while (b != 0) begin
				if (x >= r + b) begin
					x -= r + b;
					r = (r >> 1) + b;
				end else begin
					r >>= 1;
				end
				b >>= 2;
			end
			return r;
		endfunction

		function void note_item(rvu_pkg::item_t it);
			rvu_pkg::result_t e;
			logic signed [31:0] oc, os, rc, rs;
			logic [63:0] sc, sn, q;
			oc = cos_mem[slot];
			os = sin_mem[slot];
			rc = seen_vector ? relax(oc, it.new_cos) : it.new_cos;
			rs = seen_vector ? relax(os, it.new_sin) : it.new_sin;
			cos_mem[slot] = rc;
			sin_mem[slot] = rs;
			delta_acc = sat_add(delta_acc, square(longint'(rc) - longint'(oc)));
			delta_acc = sat_add(delta_acc, square(longint'(rs) - longint'(os)));
			norm_acc = sat_add(norm_acc, square(longint'(rc)));
			norm_acc = sat_add(norm_acc, square(longint'(rs)));
			e = '0;
			e.relaxed_cos = rc;
			e.relaxed_sin = rs;
			if (it.last) begin
				e.change_valid = 1'b1;
				if (!seen_vector) begin
					e.relative_change = '1;
					e.change_infinite = 1'b1;
				end else begin
					sc = root64(delta_acc);
					sn = root64(norm_acc);
					if (sn == 0) sn = 1;
					q = (sc << 16) / sn;
					e.relative_change = (q > 64'hFFFF_FFFF) ? '1 : q[31:0];
					e.converged = (e.relative_change <= tolerance);
				end
				seen_vector = 1;
				slot = 0;
				delta_acc = '0;
				norm_acc = '0;
			end else begin
				slot = (slot + 1) % NCOEF;
			end
			owed = {owed, e};
		endfunction

		task report(string what, logic [31:0] got, logic [31:0] want);
			$display("mismatch on %s: got %h, expected %h", what, got, want);
			errors++;
		endtask

		task check_result(rvu_pkg::result_t r);
			rvu_pkg::result_t e;
			if (owed.size() == 0) begin
				report("unexpected result", r.relaxed_cos, 32'h0);
				return;
			end
			e = owed.pop_front();
			if (r.relaxed_cos !== e.relaxed_cos)
				report("relaxed_cos", r.relaxed_cos, e.relaxed_cos);
			if (r.relaxed_sin !== e.relaxed_sin)
				report("relaxed_sin", r.relaxed_sin, e.relaxed_sin);
			if (r.change_valid !== e.change_valid)
				report("change_valid", r.change_valid, e.change_valid);
			if (r.relative_change !== e.relative_change)
				report("relative_change", r.relative_change, e.relative_change);
			if (r.change_infinite !== e.change_infinite)
				report("change_infinite", r.change_infinite, e.change_infinite);
			if (r.converged !== e.converged)
				report("converged", r.converged, e.converged);
		endtask
	endclass

	update_scoreboard board = new();

	// last value sent per element, so later vectors can stay close to it
	logic signed [31:0] sent_cos[NCOEF];
	logic signed [31:0] sent_sin[NCOEF];

	function automatic bit calm();
		return cyc >= 4000 && cyc < 9000;
	endfunction

	// receiver: pops at random, checks what leaves at each edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty)
				board.check_result(result);
			pop <= calm() || ($urandom_range(99) >= 7);
		end
	end

	task automatic write_reg(logic [rvu_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
		@(posedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= data;
		board.write_reg(idx, data);
		@(posedge clk);
		wr_en <= 1'b0;
	endtask

	// send one item, keeping push high into the next one
	task automatic send_item(logic signed [31:0] c, logic signed [31:0] s, bit last);
		rvu_pkg::item_t it;
		it.new_cos = c;
		it.new_sin = s;
		it.last = last;
		if (!calm() && $urandom_range(99) < 7) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		push <= 1'b1;
		item <= it;
		do @(posedge clk); while (full);
		board.note_item(it);
	endtask

	task automatic drain();
		push <= 1'b0;
		while (board.owed.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(7))
			0: return 32'sh8000_0000;
			1: return 32'sh7FFF_FFFF;
			2: return 32'sd0;
			3: return -32'sd1;
			4: return $signed($urandom_range(0, 32'h0002_0000)) - 32'sh0001_0000;
			default: return $urandom;
		endcase
	endfunction

	// next value for an element: mostly near the last one, so vectors converge
	function automatic logic signed [31:0] near(logic signed [31:0] prev);
		case ($urandom_range(9))
			0, 1, 2: return prev;
			3, 4, 5, 6: return prev + $signed($urandom_range(0, 64)) - 32'sd32;
			default: return pick_value();
		endcase
	endfunction

	task automatic send_vector(int unsigned len);
		logic signed [31:0] c, s;
		for (int unsigned k = 0; k < len; k++) begin
			c = near(sent_cos[k % NCOEF]);
			s = near(sent_sin[k % NCOEF]);
			sent_cos[k % NCOEF] = c;
			sent_sin[k % NCOEF] = s;
			send_item(c, s, k == len - 1);
		end
	endtask

	initial begin
		int unsigned sent;
		int unsigned len;
		logic [31:0] rf, tol;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// first vector fills every element, so no later read finds an empty one;
		// it opens with the field extremes and is copied through unchanged
		send_item(32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0);
		send_item(32'sh7FFF_FFFF, 32'sh8000_0000, 1'b0);
		send_item(32'sd0, -32'sd1, 1'b0);
		send_item(-32'sd1, 32'sd0, 1'b0);
		for (int k = 0; k < 4; k++) begin
			sent_cos[k] = board.cos_mem[k];
			sent_sin[k] = board.sin_mem[k];
		end
		for (int k = 4; k < NCOEF; k++) begin
			sent_cos[k] = pick_value();
			sent_sin[k] = pick_value();
			send_item(sent_cos[k], sent_sin[k], k == NCOEF - 1);
		end
		// identical vector: zero change, converged at the reset tolerance
		for (int k = 0; k < 8; k++)
			send_item(sent_cos[k], sent_sin[k], k == 7);
		// single-element vector of extremes against the stored ones
		send_item(32'sh8000_0000, 32'sh7FFF_FFFF, 1'b1);
		sent_cos[0] = 32'sh8000_0000;
		sent_sin[0] = 32'sh7FFF_FFFF;
		drain();

		// phases over the register settings, extremes first
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: begin rf = 32'd65536; tol = 32'd0; end
				1: begin rf = 32'd1; tol = 32'hFFFF_FFFF; end
				2: begin rf = 32'h0001_FFFF; tol = 32'd66; end
				3: begin rf = 32'd0; tol = $urandom; end
				4: begin rf = 32'hFFFE_0000 | 32'd32768; tol = 32'd6554; end
				default: begin
					rf = $urandom_range(1, 65536);
					tol = $urandom_range(0, 32'h0002_0000);
				end
			endcase
			write_reg(rvu_pkg::REG_RELAX_FACTOR, rf);
			write_reg(rvu_pkg::REG_CHANGE_TOL, tol);
			write_reg(REG_UNUSED, $urandom);
			sent = 0;
			while (sent < 190) begin
				// mostly short vectors, now and then one that fills or wraps the store
				len = ($urandom_range(99) < 4) ? $urandom_range(NCOEF, NCOEF + 40)
				                               : $urandom_range(1, 24);
				send_vector(len);
				sent += len;
			end
			drain();
		end

		if (board.errors == 0)
			$display("relaxed_vector_update_with_change_norm_unit_test passed");
		else
			$display("relaxed_vector_update_with_change_norm_unit_test failed");
		$finish;
	end

	initial begin
		#20000000;
		$display("relaxed_vector_update_with_change_norm_unit_test failed");
		$finish;
	end

endmodule

// File: sim.f
hw/rtl/rvu_pkg.sv
hw/rtl/rvu_fifo.sv
hw/rtl/rvu_front.sv
hw/rtl/rvu_back.sv
hw/rtl/relaxed_vector_update_with_change_norm_unit.sv
hw/rtl/rvu_chk.sv
dv/relaxed_vector_update_with_change_norm_unit_test.sv
